@@ hdl/sbus_fd_pkg.sv @@
package sbus_fd_pkg;

    localparam int FRAME_BYTES = 24;
    // The end byte is checked but never stored
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int CNT_W       = 5;
    localparam int CHAN_COUNT  = 16;
    localparam int CHAN_W      = 11;
    localparam int IDX_W       = 4;
    localparam int CHAN_BYTES  = 22;
    localparam int PACK_W      = CHAN_BYTES * 8;
    localparam int FLAG_BYTE   = 22;

    localparam int FLAG_LOST_BIT     = 2;
    localparam int FLAG_FAILSAFE_BIT = 3;
    localparam int FLAG_LINK_BIT     = 5;

    localparam logic [CNT_W-1:0] LAST_BYTE   = CNT_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_CHAN   = IDX_W'(CHAN_COUNT - 1);
    localparam logic [7:0]       START_BYTE  = 8'h0F;
    localparam logic [7:0]       TIMEOUT_RST = 8'h04;

    localparam logic [7:0] END_00 = 8'h00;
    localparam logic [7:0] END_04 = 8'h04;
    localparam logic [7:0] END_14 = 8'h14;
    localparam logic [7:0] END_24 = 8'h24;
    localparam logic [7:0] END_34 = 8'h34;
    localparam logic [7:0] END_08 = 8'h08;

    function automatic logic is_good_end(input logic [7:0] b);
        logic ok;
        case (b) inside
            END_00, END_04, END_14, END_24, END_34, END_08: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ hdl/sbus_fd_if.sv @@
interface sbus_fd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;

    modport source (output valid, output rx_byte, output now_ms, input ready);
    modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

interface sbus_fd_out_if;
    logic                          valid;
    logic                          ready;
    logic [sbus_fd_pkg::IDX_W-1:0]  channel_index;
    logic [sbus_fd_pkg::CHAN_W-1:0] channel_value;
    logic                          frame_ok;
    logic                          failsafe;
    logic                          link_lost;
    logic                          last;

    modport source (
        output valid, output channel_index, output channel_value,
        output frame_ok, output failsafe, output link_lost, output last,
        input ready
    );
    modport sink (
        input valid, input channel_index, input channel_value,
        input frame_ok, input failsafe, input link_lost, input last,
        output ready
    );
endinterface

@@ hdl/sbus_frame_decoder_core.sv @@
// Serial radio-control frame decoder, sixteen 11-bit channels.
// i_in carries one received byte per beat with its arrival time in ms.
// Each byte is first held in an input register and handled from there:
// start-byte hunt, timeout check, storing into the frame buffer.
// A byte that ends a frame with a good end byte copies the 22 channel
// bytes and the flag byte into the result buffer, which then drives
// o_out for 16 beats, channel 0 to 15, last set on channel 15.
// The end byte passes the input register and then loads the result
// buffer, which drives the first channel beat. Throughput: one input
// byte per cycle while none is held (below); 16 output beats per frame
// at one per cycle while the receiver takes them. When it stalls, the
// result buffer holds its beat; input bytes flow on until a byte ending
// a frame meets it busy and waits in the input register, i_in.ready low.
// i_cfg_wr_en/i_cfg_wr_data set the timeout (ms after the start byte).
// Reset (synchronous, active low) empties both registers, drops any
// partial frame and sets the timeout to 4 ms.
module sbus_frame_decoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    sbus_fd_in_if.sink          i_in,
    sbus_fd_out_if.source       o_out
);

    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;
    logic [31:0]                       r_in_now;
    logic [7:0]                        r_timeout;

    logic                              r_in_frame;
    logic                              n_in_frame;
    logic [sbus_fd_pkg::CNT_W-1:0]     r_byte_count;
    logic [sbus_fd_pkg::CNT_W-1:0]     n_byte_count;
    logic [31:0]                       r_start_ms;
    logic [31:0]                       n_start_ms;
    logic [7:0]                        r_store [sbus_fd_pkg::STORE_DEPTH];

    logic                              r_out_valid;
    logic [sbus_fd_pkg::PACK_W-1:0]    r_chan_buf;
    logic [sbus_fd_pkg::IDX_W-1:0]     r_chan_idx;
    logic                              r_frame_ok;
    logic                              r_failsafe;
    logic                              r_link_lost;

    logic                              timed_out;
    logic                              live;
    logic                              ends;
    logic                              advance;
    logic                              load;
    logic                              out_take;
    logic [sbus_fd_pkg::PACK_W-1:0]    packed_chans;
    logic [7:0]                        flags;

    assign timed_out = {1'b0, r_in_now} > ({1'b0, r_start_ms} + 33'(r_timeout));
    assign live      = r_in_frame && !timed_out;
    assign ends      = live && (r_byte_count == sbus_fd_pkg::LAST_BYTE);
    // Hold a frame-ending byte while the result buffer is still busy
    assign advance   = r_in_valid && !(ends && r_out_valid);
    assign load      = advance && ends && sbus_fd_pkg::is_good_end(r_in_byte);
    assign out_take  = r_out_valid && o_out.ready;

    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        for (int i = 0; i < sbus_fd_pkg::CHAN_BYTES; i++) begin
            packed_chans[8*i +: 8] = r_store[i];
        end
    end

    assign flags = r_store[sbus_fd_pkg::FLAG_BYTE];

    always_comb begin
        n_in_frame   = r_in_frame;
        n_byte_count = r_byte_count;
        n_start_ms   = r_start_ms;
        if (advance) begin
            if (!live) begin
                n_in_frame = 1'b0;
                if (r_in_byte == sbus_fd_pkg::START_BYTE) begin
                    n_in_frame   = 1'b1;
                    n_byte_count = '0;
                    n_start_ms   = r_in_now;
                end
            end else if (ends) begin
                n_in_frame   = 1'b0;
                n_byte_count = '0;
            end else begin
                n_byte_count = r_byte_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_timeout    <= sbus_fd_pkg::TIMEOUT_RST;
            r_in_frame   <= 1'b0;
            r_byte_count <= '0;
            r_start_ms   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            r_in_frame   <= n_in_frame;
            r_byte_count <= n_byte_count;
            r_start_ms   <= n_start_ms;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_take && (r_chan_idx == sbus_fd_pkg::LAST_CHAN)) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
            r_in_now  <= i_in.now_ms;
        end
        if (advance && live && !ends) begin
            r_store[r_byte_count] <= r_in_byte;
        end
        if (load) begin
            r_chan_buf  <= packed_chans;
            r_chan_idx  <= '0;
            r_frame_ok  <= !flags[sbus_fd_pkg::FLAG_LOST_BIT];
            r_failsafe  <= flags[sbus_fd_pkg::FLAG_FAILSAFE_BIT];
            r_link_lost <= flags[sbus_fd_pkg::FLAG_LINK_BIT];
        end else if (out_take) begin
            // Advance to the next channel
            r_chan_buf <= r_chan_buf >> sbus_fd_pkg::CHAN_W;
            r_chan_idx <= r_chan_idx + 1'b1;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.channel_index = r_chan_idx;
    assign o_out.channel_value = r_chan_buf[sbus_fd_pkg::CHAN_W-1:0];
    assign o_out.frame_ok      = r_frame_ok;
    assign o_out.failsafe      = r_failsafe;
    assign o_out.link_lost     = r_link_lost;
    assign o_out.last          = (r_chan_idx == sbus_fd_pkg::LAST_CHAN);

endmodule

@@ hdl/sbus_fd_checker.sv @@
module sbus_fd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [sbus_fd_pkg::IDX_W-1:0]  i_channel_index,
    input logic [sbus_fd_pkg::CHAN_W-1:0] i_channel_value,
    input logic                           i_frame_ok,
    input logic                           i_failsafe,
    input logic                           i_link_lost,
    input logic                           i_last
);

    logic out_beat;
    assign out_beat = i_out_valid && i_out_ready;

    // A stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_channel_index) && $stable(i_channel_value))
        else $error("stalled beat changed");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_channel_index == sbus_fd_pkg::LAST_CHAN)))
        else $error("last does not match channel 15");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && !i_last |=>
            i_out_valid && (i_channel_index == 4'($past(i_channel_index) + 4'd1)))
        else $error("channel run broken");

    a_new_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && i_last |=> !i_out_valid || (i_channel_index == '0))
        else $error("frame does not start at channel 0");

    a_flags_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && !i_last |=>
            $stable(i_frame_ok) && $stable(i_failsafe) && $stable(i_link_lost))
        else $error("flags changed within a frame");

endmodule

bind sbus_frame_decoder_core sbus_fd_checker u_sbus_fd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_channel_index (o_out.channel_index),
    .i_channel_value (o_out.channel_value),
    .i_frame_ok      (o_out.frame_ok),
    .i_failsafe      (o_out.failsafe),
    .i_link_lost     (o_out.link_lost),
    .i_last          (o_out.last)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int          RANDOM_BYTES = 300;
    localparam int          PHASES       = 5;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          SETTLE       = 8;
    localparam int          MAX_SHOWN    = 10;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [sbus_fd_pkg::IDX_W-1:0]  idx;
        logic [sbus_fd_pkg::CHAN_W-1:0] value;
        logic                           ok;
        logic                           failsafe;
        logic                           link_lost;
        logic                           last;
    } t_chan_beat;

    typedef enum {SEQ_GOOD, SEQ_BAD_END, SEQ_TIMED_OUT} t_seq_kind;

    class t_frame_scoreboard;
        logic [7:0]                    timeout_ms;
        logic                          in_frame;
        logic [sbus_fd_pkg::CNT_W-1:0] byte_cnt;
        logic [7:0]                    store [sbus_fd_pkg::FRAME_BYTES];
        logic [31:0]                   start_ms;
        t_chan_beat                    pending_beats[$];
        int unsigned                   errors;

        function new();
            timeout_ms = sbus_fd_pkg::TIMEOUT_RST;
            in_frame   = 1'b0;
            byte_cnt   = '0;
            start_ms   = '0;
            errors     = 0;
        endfunction

        // Note one accepted byte and queue the channel beats that it releases
        function void note_byte(logic [7:0] b, logic [31:0] t);
            logic [32:0]                    deadline;
            logic [sbus_fd_pkg::PACK_W-1:0] chan_bits;
            logic [7:0]                     flags;
            deadline = {1'b0, start_ms} + {25'd0, timeout_ms};
            if ({1'b0, t} > deadline) in_frame = 1'b0;
            if (!in_frame) begin
                if (b == sbus_fd_pkg::START_BYTE) begin
                    in_frame = 1'b1;
                    byte_cnt = '0;
                    start_ms = t;
                end
                return;
            end
            store[byte_cnt] = b;
            if (byte_cnt != sbus_fd_pkg::LAST_BYTE) begin
                byte_cnt++;
                return;
            end
            in_frame = 1'b0;
            byte_cnt = '0;
            if (!(b inside {sbus_fd_pkg::END_00, sbus_fd_pkg::END_04, sbus_fd_pkg::END_14,
                            sbus_fd_pkg::END_24, sbus_fd_pkg::END_34, sbus_fd_pkg::END_08}))
                return;
            for (int i = 0; i < sbus_fd_pkg::CHAN_BYTES; i++) chan_bits[8*i +: 8] = store[i];
            flags = store[sbus_fd_pkg::FLAG_BYTE];
            for (int k = 0; k < sbus_fd_pkg::CHAN_COUNT; k++) begin
                pending_beats.push_back(t_chan_beat'{
                    sbus_fd_pkg::IDX_W'(k),
                    chan_bits[sbus_fd_pkg::CHAN_W*k +: sbus_fd_pkg::CHAN_W],
                    ~flags[sbus_fd_pkg::FLAG_LOST_BIT],
                    flags[sbus_fd_pkg::FLAG_FAILSAFE_BIT],
                    flags[sbus_fd_pkg::FLAG_LINK_BIT],
                    k == sbus_fd_pkg::CHAN_COUNT - 1});
            end
        endfunction

        function void check_beat(t_chan_beat got);
            t_chan_beat want;
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected beat: idx=%0d val=%0d ok=%0b fs=%0b ll=%0b last=%0b",
                             got.idx, got.value, got.ok, got.failsafe, got.link_lost, got.last);
                return;
            end
            want = pending_beats.pop_front();
            if (got.idx !== want.idx || got.value !== want.value || got.ok !== want.ok ||
                got.failsafe !== want.failsafe || got.link_lost !== want.link_lost ||
                got.last !== want.last) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("beat differs: exp idx=%0d val=%0d ok=%0b fs=%0b ll=%0b last=%0b",
                             want.idx, want.value, want.ok, want.failsafe, want.link_lost,
                             want.last);
                    $display("              got idx=%0d val=%0d ok=%0b fs=%0b ll=%0b last=%0b",
                             got.idx, got.value, got.ok, got.failsafe, got.link_lost, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;

    sbus_fd_in_if  in_if ();
    sbus_fd_out_if out_if ();

    sbus_frame_decoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    t_frame_scoreboard sb = new();

    logic [31:0] wall_ms;
    int unsigned sent;
    int unsigned good_count;
    int unsigned tx_calm;
    int unsigned rx_calm;
    int unsigned cycles;
    logic        hold_req;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one or a calm stretch
    function automatic int unsigned gap_len(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] good_end_code(int unsigned n);
        case (n % 6)
            0: return sbus_fd_pkg::END_00;
            1: return sbus_fd_pkg::END_04;
            2: return sbus_fd_pkg::END_14;
            3: return sbus_fd_pkg::END_24;
            4: return sbus_fd_pkg::END_34;
            default: return sbus_fd_pkg::END_08;
        endcase
    endfunction

    // Advance the clock in ms, holding at the top instead of wrapping
    task automatic bump_ms(input logic [31:0] d);
        if (wall_ms > 32'hFFFF_FFFF - d) wall_ms = '1;
        else wall_ms = wall_ms + d;
    endtask

    task automatic put_byte(input logic [7:0] b);
        int unsigned gap;
        gap = gap_len(tx_calm);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        in_if.now_ms  <= wall_ms;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_byte(b, wall_ms);
        sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [7:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.timeout_ms = v;
    endtask

    task automatic send_frame(input t_seq_kind kind);
        logic [32:0] clear_at;
        logic [31:0] t0;
        logic [7:0]  data [sbus_fd_pkg::FRAME_BYTES];
        int unsigned fill;
        int unsigned cut;
        int          i;
        // let a frame left open by stray bytes time out first
        if (sb.in_frame) begin
            clear_at = {1'b0, sb.start_ms} + {25'd0, sb.timeout_ms} + 33'd1;
            if (clear_at > {1'b0, wall_ms}) wall_ms = clear_at[32] ? '1 : clear_at[31:0];
        end
        fill = $urandom_range(0, 9);
        for (i = 0; i < sbus_fd_pkg::FRAME_BYTES; i++) begin
            if (fill == 0) data[i] = 8'h00;
            else if (fill == 1) data[i] = 8'hFF;
            else data[i] = 8'($urandom);
            if ($urandom_range(0, 15) == 0) data[i] = sbus_fd_pkg::START_BYTE;
        end
        if (kind == SEQ_BAD_END) begin
            while (data[sbus_fd_pkg::LAST_BYTE] inside {
                       sbus_fd_pkg::END_00, sbus_fd_pkg::END_04, sbus_fd_pkg::END_14,
                       sbus_fd_pkg::END_24, sbus_fd_pkg::END_34, sbus_fd_pkg::END_08})
                data[sbus_fd_pkg::LAST_BYTE] = 8'($urandom);
        end else begin
            data[sbus_fd_pkg::LAST_BYTE] = good_end_code(good_count);
            good_count++;
        end
        cut = $urandom_range(1, sbus_fd_pkg::FRAME_BYTES - 1);
        put_byte(sbus_fd_pkg::START_BYTE);
        t0 = wall_ms;
        i = 0;
        while (i < sbus_fd_pkg::FRAME_BYTES) begin
            if (kind == SEQ_TIMED_OUT && i == cut) begin
                bump_ms(32'(sb.timeout_ms) + 32'd1 + 32'($urandom_range(0, 5)));
                kind = SEQ_GOOD;
                if ($urandom_range(0, 1) != 0) begin
                    // a late start byte opens a fresh frame straight away
                    put_byte(sbus_fd_pkg::START_BYTE);
                    t0 = wall_ms;
                    i = 0;
                end
            end
            if ($urandom_range(0, 5) == 0 && wall_ms - t0 < 32'(sb.timeout_ms)) bump_ms(1);
            put_byte(data[i]);
            i++;
        end
    endtask

    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            bump_ms($urandom_range(0, 3));
            put_byte(($urandom_range(0, 7) == 0) ? sbus_fd_pkg::START_BYTE : 8'($urandom));
        end
    endtask

    initial begin
        int unsigned r;
        int unsigned phase_goal;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_if.valid   <= 1'b0;
        in_if.rx_byte <= '0;
        in_if.now_ms  <= '0;
        hold_req   = 1'b0;
        tx_calm    = 0;
        sent       = 0;
        good_count = 0;
        wall_ms    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // channels 0..7 at full scale, 8..14 at zero, a start byte in the data of channel 15
        put_byte(sbus_fd_pkg::START_BYTE);
        for (int i = 0; i < sbus_fd_pkg::FRAME_BYTES; i++) begin
            if (i < 11) put_byte(8'hFF);
            else if (i == sbus_fd_pkg::CHAN_BYTES - 1) put_byte(sbus_fd_pkg::START_BYTE);
            else if (i == sbus_fd_pkg::FLAG_BYTE) put_byte(8'h2C);
            else if (i == sbus_fd_pkg::FRAME_BYTES - 1) put_byte(sbus_fd_pkg::END_34);
            else put_byte(8'h00);
        end
        wall_ms = $urandom;

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                drain();
                case (p)
                    1: write_timeout(8'd0);
                    2: write_timeout(8'($urandom_range(5, 200)));
                    3: write_timeout(8'd2);
                    default: write_timeout(8'd255);
                endcase
                wall_ms = (p == PHASES - 1) ? 32'hFFFF_FF00 : 32'($urandom);
            end
            if (p == 2) begin
                // back-pressure the output while frames keep arriving
                hold_req = 1'b1;
                repeat (3) send_frame(SEQ_GOOD);
            end
            phase_goal = sent + RANDOM_BYTES / PHASES;
            while (sent < phase_goal) begin
                r = $urandom_range(0, 99);
                if (r < 60) send_frame(SEQ_GOOD);
                else if (r < 72) send_frame(SEQ_BAD_END);
                else if (r < 86) send_frame(SEQ_TIMED_OUT);
                else send_noise();
                bump_ms($urandom_range(0, 2));
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) $display("sbus_frame_decoder_core: match");
        else $display("sbus_frame_decoder_core: mismatch");
        $finish;
    end

    initial begin
        int unsigned gap;
        rx_calm = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
                gap = gap_len(rx_calm);
                if (gap != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_beat(t_chan_beat'{out_if.channel_index, out_if.channel_value,
                                       out_if.frame_ok, out_if.failsafe, out_if.link_lost,
                                       out_if.last});
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sbus_frame_decoder_core: mismatch");
            $finish;
        end
    end

endmodule

@@ sbus_frame_decoder_core.f @@
hdl/sbus_fd_pkg.sv
hdl/sbus_fd_if.sv
hdl/sbus_frame_decoder_core.sv
hdl/sbus_fd_checker.sv
tb/tb_top.sv
